[src/prr_pkg.sv]
`timescale 1ns / 1ps
// prr_pkg: shared types and constants for the polyphase rational resampler
// no dependencies

package prr_pkg;

	localparam int MAX_TAPS     = 256;
	localparam int MAX_UP       = 16;
	localparam int SAMPLE_WIDTH = 16;
	localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
	localparam int TAP_AW       = $clog2(MAX_TAPS);
	localparam int ACC_W        = 2 * SAMPLE_WIDTH + TAP_AW;
	localparam int SCL_W        = ACC_W + 5;
	localparam int OFF_W        = 12;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_UP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAPS = 2'd2;

	typedef enum logic [0:0] {
		OP_SAMPLE = 1'b0,
		OP_COEF   = 1'b1
	} op_t;

	typedef struct packed {
		op_t                            operation;
		logic [7:0]                     coef_index;
		logic signed [SAMPLE_WIDTH-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           last;
	} out_item_t;

	typedef struct packed {
		logic clr;
		logic prod_en;
		logic acc_en;
		logic scale_en;
	} mac_ctl_t;

endpackage

[src/prr_ram.sv]
`timescale 1ns / 1ps
// prr_ram: generic single write port, single read port ram with registered read
// no dependencies

module prr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/prr_mac.sv]
`timescale 1ns / 1ps
// prr_mac: shared multiply-accumulate unit with gain scaling, rounding and saturation
// depends on prr_pkg

module prr_mac
	import prr_pkg::*;
(
	input  logic                           clk,
	input  mac_ctl_t                       ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] coef,
	input  logic signed [SAMPLE_WIDTH-1:0] smp,
	input  logic [4:0]                     gain,
	output logic signed [SAMPLE_WIDTH-1:0] result
);

	localparam int SHR_W = SCL_W + 1 - FRAC_BITS;
	localparam logic signed [SCL_W:0] RND_C = (SCL_W + 1)'(1) << (FRAC_BITS - 1);

	logic signed [2*SAMPLE_WIDTH-1:0] prod_s2;
	logic signed [ACC_W-1:0]          acc_q;
	logic signed [SCL_W-1:0]          scl_q;
	logic signed [SCL_W:0]            rnd;
	logic [SHR_W-1:0]                 shr;
	logic [SHR_W-SAMPLE_WIDTH:0]      top;

	always_ff @(posedge clk) begin
		if (ctl.prod_en) begin
			prod_s2 <= coef * smp;
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (ctl.scale_en) begin
			scl_q <= SCL_W'(acc_q) * SCL_W'($signed({1'b0, gain}));
		end
	end

	// round half up, then saturate
	always_comb begin
		rnd = (SCL_W + 1)'(scl_q) + RND_C;
		shr = rnd[SCL_W:FRAC_BITS];
		top = shr[SHR_W-1:SAMPLE_WIDTH-1];
		if (top == '0 || top == '1) begin
			result = shr[SAMPLE_WIDTH-1:0];
		end else if (shr[SHR_W-1]) begin
			result = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			result = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	end

endmodule

[src/polyphase_rational_resampler.sv]
`timescale 1ns / 1ps
// polyphase_rational_resampler: upsample by U, fir low-pass, downsample by D
// depends on prr_pkg, prr_ram, prr_mac
// coefficient beat: written while idle. sample beat: in_stall holds until every output of it
// is done; an output of phase p takes ceil((taps - p) / U) taps, bound by the single shared
// multiply-accumulate, and waits longer while out_stall holds; one tap per cycle
// reset: delay line reads as zeros through a fill count, no clearing pass; offset zero,
// U = 1, D = 1, 256 taps; coefficient store undefined until written

module polyphase_rational_resampler
	import prr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_ISSUE,
		S_DRAIN,
		S_SCALE,
		S_EMIT
	} state_t;

	state_t                         state_q;
	logic [4:0]                     up_q;
	logic [6:0]                     down_q;
	logic [8:0]                     taps_q;
	logic [4:0]                     u_eff;
	logic [6:0]                     d_eff;
	logic [8:0]                     taps_eff;
	logic [TAP_AW-1:0]              head_q;
	logic [TAP_AW:0]                fill_q;
	logic [OFF_W-1:0]               off_q;
	logic [8:0]                     t_q;
	logic [TAP_AW-1:0]              k_q;
	logic                           iss;
	logic                           live;
	logic                           iss_s1;
	logic                           live_s1;
	logic                           iss_s2;
	logic                           accept;
	logic                           out_free;
	logic                           out_valid_q;
	out_item_t                      out_q;
	logic [SAMPLE_WIDTH-1:0]        dl_rdata;
	logic [SAMPLE_WIDTH-1:0]        cf_rdata;
	logic signed [SAMPLE_WIDTH-1:0] mac_smp;
	logic signed [SAMPLE_WIDTH-1:0] mac_res;
	mac_ctl_t                       mac_ctl;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q   <= 5'd1;
			down_q <= 7'd1;
			taps_q <= 9'(MAX_TAPS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_UP:   up_q   <= cfg_data[4:0];
				CFG_DOWN: down_q <= cfg_data[6:0];
				CFG_TAPS: taps_q <= cfg_data[8:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		if (up_q == '0) begin
			u_eff = 5'd1;
		end else if (up_q > 5'(MAX_UP)) begin
			u_eff = 5'(MAX_UP);
		end else begin
			u_eff = up_q;
		end
		d_eff = (down_q == '0) ? 7'd1 : down_q;
		if (taps_q == '0) begin
			taps_eff = 9'd1;
		end else if (taps_q > 9'(MAX_TAPS)) begin
			taps_eff = 9'(MAX_TAPS);
		end else begin
			taps_eff = taps_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign iss     = (state_q == S_ISSUE) && (t_q < taps_eff);
	assign live    = ({1'b0, k_q} < fill_q);
	assign mac_smp = live_s1 ? $signed(dl_rdata) : '0;

	assign mac_ctl.clr      = (state_q == S_START);
	assign mac_ctl.prod_en  = iss_s1;
	assign mac_ctl.acc_en   = iss_s2;
	assign mac_ctl.scale_en = (state_q == S_SCALE);

	prr_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(MAX_TAPS)
	) u_delay (
		.clk  (clk),
		.we   (accept && in_data.operation == OP_SAMPLE),
		.waddr(head_q + TAP_AW'(1)),
		.wdata(in_data.value),
		.raddr(head_q - k_q),
		.rdata(dl_rdata)
	);

	prr_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(MAX_TAPS)
	) u_coef (
		.clk  (clk),
		.we   (accept && in_data.operation == OP_COEF),
		.waddr(in_data.coef_index),
		.wdata(in_data.value),
		.raddr(t_q[TAP_AW-1:0]),
		.rdata(cf_rdata)
	);

	prr_mac u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.coef  ($signed(cf_rdata)),
		.smp   (mac_smp),
		.gain  (u_eff),
		.result(mac_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			off_q       <= '0;
			t_q         <= '0;
			k_q         <= '0;
			iss_s1      <= 1'b0;
			live_s1     <= 1'b0;
			iss_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			iss_s1  <= iss;
			live_s1 <= live;
			iss_s2  <= iss_s1;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && in_data.operation == OP_SAMPLE) begin
						head_q  <= head_q + TAP_AW'(1);
						if (fill_q != (TAP_AW + 1)'(MAX_TAPS)) begin
							fill_q <= fill_q + (TAP_AW + 1)'(1);
						end
						state_q <= S_START;
					end
				end
				S_START: begin
					if (off_q < OFF_W'(u_eff)) begin
						t_q     <= 9'(off_q);
						k_q     <= '0;
						state_q <= S_ISSUE;
					end else begin
						off_q   <= off_q - OFF_W'(u_eff);
						state_q <= S_IDLE;
					end
				end
				S_ISSUE: begin
					if (iss) begin
						t_q <= t_q + 9'(u_eff);
						k_q <= k_q + TAP_AW'(1);
					end else begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!iss_s1 && !iss_s2) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_q.sample <= mac_res;
						out_q.last   <= ((off_q + OFF_W'(d_eff)) >= OFF_W'(u_eff));
						out_valid_q  <= 1'b1;
						off_q        <= off_q + OFF_W'(d_eff);
						state_q      <= S_START;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
